FILE: rtl/art_pkg.sv
//------------------------------------------------------------------------------
// art_pkg: shared types and constants of the address region table
// Holds the slot geometry, operation and status codes and the entry layout.
//------------------------------------------------------------------------------
`default_nettype none

package art_pkg;

  localparam int unsigned MaxRegions = 16;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned EntryW     = 72;  // start, length, flags
  localparam logic [31:0] UserLimit  = 32'hC000_0000;

  typedef enum logic [1:0] {
    FUNC_FIND   = 2'd0,
    FUNC_CREATE = 2'd1,
    FUNC_RESIZE = 2'd2,
    FUNC_DELETE = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_NOT_FOUND = 4'd1,
    ST_KERNEL    = 4'd2,
    ST_MISALIGN  = 4'd3,
    ST_WRAPS     = 4'd4,
    ST_RANGE     = 4'd5,
    ST_OVERLAP   = 4'd6,
    ST_FULL      = 4'd7,
    ST_BAD_SLOT  = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SLOT,
    S_DECIDE,
    S_OUT
  } state_e;

  localparam logic CfgKernel = 1'b0;
  localparam logic CfgMask   = 1'b1;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic [7:0]  flags;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/art_ram.sv
//------------------------------------------------------------------------------
// art_ram: generic single-port RAM
// One write or read per cycle, read data registered.
//------------------------------------------------------------------------------
`default_nettype none

module art_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write or read one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/address_region_table.sv
//------------------------------------------------------------------------------
// address_region_table: slot table of non-overlapping user address regions
// Find, create, resize and delete regions held in a single-port entry RAM.
//------------------------------------------------------------------------------
// Usage:
//   Requests enter on s_axis (func, address, length, flags, slot in tdata),
//   one result leaves on m_axis per request. Registers are written through
//   cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must write them only while
//   the block is idle, which the block itself does not enforce.
//   Each request walks the entry RAM once, one slot a cycle, with registered
//   read data. Find and create go from IDLE through SCAN to DECIDE, which
//   hands the result to the output register and returns to IDLE. Resize and
//   delete first read the addressed slot in SLOT before SCAN. The single RAM
//   port makes the walk serial. s_axis_tready is high only while idle; a new
//   request is taken once the result is handed to the output register, so one
//   result may wait while the next request scans. Reset clears valid bits
//   and control state and sets the mask to all ones; the entry RAM needs
//   no clearing since an entry is used only while its valid bit is set.
//   A stalled receiver holds the result; a further result waits in DECIDE.
//------------------------------------------------------------------------------
`default_nettype none

module address_region_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // func[1:0], address[33:2], length[65:34], flags[73:66], slot[77:74]
  input  wire logic [79:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[3:0], found_slot[7:4], region_start[39:8], region_length[71:40],
  // region_flags[79:72], freed_start[111:80], freed_end[143:112]
  output logic [143:0]     m_axis_tdata
);
  import art_pkg::*;

  state_e state_q, state_d;
  logic       kernel_q;
  logic [7:0] mask_q;
  logic [MaxRegions-1:0] valid_q;

  // request
  logic [1:0]  func_q;
  logic [31:0] addr_q, len_q, end_lo_q;
  logic [7:0]  flg_q;
  logic [SlotW-1:0] sl_q;
  logic        end_c_q;

  // scan
  logic [SlotW:0]   cnt_q;       // issue counter
  logic [SlotW-1:0] rd_q;        // slot whose data arrives
  logic             rd_v_q;
  logic             found_q, prev_v_q, next_v_q, free_v_q;
  logic [SlotW-1:0] found_s_q, free_s_q;
  logic [31:0] prev_st_q, prev_len_q, next_st_q;
  entry_t      hit_q;

  // output register
  logic         out_v_q;
  logic [143:0] out_q;

  // RAM
  logic             we;
  logic [SlotW-1:0] ram_a;
  entry_t           wdat, rdat;

  art_ram #(.Width(EntryW), .Depth(MaxRegions)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (ram_a),
    .wdata_i(wdat),
    .rdata_o(rdat)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // scan-side compares on returning data
  logic [32:0] re_sum;
  logic        rv;
  assign re_sum = {1'b0, rdat.start} + {1'b0, rdat.length};
  assign rv     = rd_v_q && valid_q[rd_q];

  // decide-stage values (hit_q holds the addressed slot for resize/delete)
  logic [32:0] nend, pend, oend;
  logic [143:0] res;
  logic         wr_en, clr_en;
  logic [SlotW-1:0] wr_s;
  entry_t       wr_e;
  status_e      st;
  assign nend = {1'b0, hit_q.start} + {1'b0, len_q};
  assign oend = {1'b0, hit_q.start} + {1'b0, hit_q.length};
  assign pend = {1'b0, prev_st_q} + {1'b0, prev_len_q};

  always_comb begin
    st = ST_OK; res = '0; wr_en = 1'b0; clr_en = 1'b0;
    wr_s = sl_q; wr_e = hit_q;
    case (func_q)
      FUNC_FIND: begin
        if (kernel_q) st = ST_KERNEL;
        else if (!found_q) st = ST_NOT_FOUND;
        else begin
          res = {oend[31:0], oend[31:0], hit_q.flags, hit_q.length, hit_q.start,
                 found_s_q, 4'd0};
        end
      end
      FUNC_CREATE: begin
        if (kernel_q) st = ST_KERNEL;
        else if (addr_q[11:0] != '0 || len_q[11:0] != '0) st = ST_MISALIGN;
        else if (end_c_q) st = ST_WRAPS;
        else if (addr_q == '0 || end_lo_q >= UserLimit) st = ST_RANGE;
        else if ((prev_v_q && {1'b0, addr_q} <= pend) ||
                 (next_v_q && next_st_q <= end_lo_q)) st = ST_OVERLAP;
        else if (!free_v_q) st = ST_FULL;
        else begin
          wr_en = 1'b1; wr_s = free_s_q;
          wr_e  = '{start: addr_q, length: len_q, flags: flg_q & mask_q};
          res = {end_lo_q, end_lo_q, flg_q & mask_q, len_q, addr_q, free_s_q, 4'd0};
        end
      end
      FUNC_RESIZE: begin
        if (!valid_q[sl_q]) st = ST_BAD_SLOT;
        else if (len_q[11:0] != '0) st = ST_MISALIGN;
        else if (len_q < hit_q.length) begin
          wr_en = 1'b1; wr_e.length = len_q;
          res = {oend[31:0], nend[31:0], hit_q.flags, len_q, hit_q.start, sl_q, 4'd0};
        end
        else if (nend[32]) st = ST_WRAPS;
        else if (nend[31:0] > UserLimit) st = ST_RANGE;
        else if (next_v_q && {1'b0, next_st_q} <= nend) st = ST_OVERLAP;
        else begin
          wr_en = 1'b1; wr_e.length = len_q;
          res = {nend[31:0], nend[31:0], hit_q.flags, len_q, hit_q.start, sl_q, 4'd0};
        end
      end
      default: begin
        if (!valid_q[sl_q]) st = ST_BAD_SLOT;
        else begin
          clr_en = 1'b1;
          res = {oend[31:0], hit_q.start, hit_q.flags, 32'd0, hit_q.start, sl_q, 4'd0};
        end
      end
    endcase
    if (st != ST_OK) res = {140'd0, st};
  end

  // next state and RAM port
  logic last_issue;
  assign last_issue = (cnt_q == (SlotW+1)'(MaxRegions));
  always_comb begin
    state_d = state_q;
    we = 1'b0; ram_a = cnt_q[SlotW-1:0]; wdat = wr_e;
    case (state_q)
      S_IDLE: begin
        // read the addressed slot first so the scan can use its start
        ram_a = s_axis_tdata[77:74];
        if (s_axis_tvalid) begin
          state_d = (s_axis_tdata[1:0] == FUNC_RESIZE ||
                     s_axis_tdata[1:0] == FUNC_DELETE) ? S_SLOT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_issue) state_d = S_DECIDE;
      end
      S_SLOT:   state_d = S_SCAN;
      S_DECIDE: begin
        if (!out_v_q || m_axis_tready) begin
          we = wr_en; ram_a = wr_s;
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q <= 1'b0; mask_q <= 8'hFF; valid_q <= '0;
      out_v_q <= 1'b0; cnt_q <= '0; rd_v_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CfgKernel) kernel_q <= cfg_wdata_i[0];
      if (cfg_we_i && cfg_idx_i == CfgMask)   mask_q   <= cfg_wdata_i;
      rd_v_q <= (state_q == S_SCAN) && !last_issue;
      if (state_q == S_IDLE) cnt_q <= '0;
      else if (state_q == S_SCAN && !last_issue) cnt_q <= cnt_q + 1'b1;
      if (state_q == S_DECIDE && (!out_v_q || m_axis_tready)) begin
        out_v_q <= 1'b1;
        if (wr_en)  valid_q[wr_s] <= 1'b1;
        if (clr_en) valid_q[sl_q] <= 1'b0;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // request capture, scan accumulation and result payload
  always_ff @(posedge clk_i) begin
    rd_q <= cnt_q[SlotW-1:0];
    if (state_q == S_IDLE) begin
      func_q <= s_axis_tdata[1:0];   addr_q <= s_axis_tdata[33:2];
      len_q  <= s_axis_tdata[65:34]; flg_q  <= s_axis_tdata[73:66];
      sl_q   <= s_axis_tdata[77:74];
      {end_c_q, end_lo_q} <= {1'b0, s_axis_tdata[33:2]} + {1'b0, s_axis_tdata[65:34]};
      found_q <= 1'b0; prev_v_q <= 1'b0; next_v_q <= 1'b0; free_v_q <= 1'b0;
    end
    if (rd_v_q) begin
      // lowest free slot
      if (!valid_q[rd_q] && !free_v_q) begin
        free_v_q <= 1'b1; free_s_q <= rd_q;
      end
      if (rv) begin
        // first slot holding the address
        if (func_q == FUNC_FIND && !found_q && rdat.start <= addr_q &&
            {1'b0, addr_q} < re_sum) begin
          found_q <= 1'b1; found_s_q <= rd_q; hit_q <= rdat;
        end
        // previous neighbour: largest start <= address, lowest slot on ties
        if (rdat.start <= addr_q && (!prev_v_q || rdat.start > prev_st_q)) begin
          prev_v_q <= 1'b1; prev_st_q <= rdat.start; prev_len_q <= rdat.length;
        end
        // next neighbour: smallest start above address
        if (rdat.start > addr_q && (!next_v_q || rdat.start < next_st_q)) begin
          next_v_q <= 1'b1; next_st_q <= rdat.start;
        end
      end
    end
    // hold the addressed slot and scan relative to its start
    if (state_q == S_SLOT) begin
      hit_q <= rdat;
      addr_q <= rdat.start;
    end
    if (state_q == S_DECIDE && (!out_v_q || m_axis_tready)) out_q <= res;
  end

endmodule

`default_nettype wire

FILE: tb/tb_address_region_table.sv
//------------------------------------------------------------------------------
// tb_address_region_table: self-checking testbench of the address region table
// Drives find/create/resize/delete requests over the request stream, predicts
// each response from a local copy of the slot table and compares every
// response field. Covers page alignment, wrap, user limit, neighbor overlap,
// full table, bad slots, kernel context, flag masking and output back-pressure.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_address_region_table;
  import art_pkg::*;

  localparam int unsigned SettleCycles = 30;

  typedef struct {
    logic [3:0]  status;
    logic [3:0]  slot;
    logic [31:0] rstart;
    logic [31:0] rlength;
    logic [7:0]  rflags;
    logic [31:0] fstart;
    logic [31:0] fend;
  } resp_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic         cfg_idx_i;
  logic [7:0]   cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;

  // local copy of the table and registers
  logic        tbl_valid  [MaxRegions];
  logic [31:0] tbl_start  [MaxRegions];
  logic [31:0] tbl_length [MaxRegions];
  logic [7:0]  tbl_flags  [MaxRegions];
  logic        kernel_q;
  logic [7:0]  mask_q;

  resp_t pending_resp[$];
  int    mismatches;
  int    requests_sent;
  int    responses_seen;
  int    cfg_settings;
  int    status_hits[9];
  int    hold_cycles;
  bit    steady;

  address_region_table u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  //----------------------------------------------------------------------------
  // Prediction
  //----------------------------------------------------------------------------
  function automatic logic [32:0] end_of(int s);
    return {1'b0, tbl_start[s]} + {1'b0, tbl_length[s]};
  endfunction

  // valid region with the largest start at or below a
  function automatic int region_below(logic [31:0] a);
    int best;
    best = -1;
    for (int i = 0; i < MaxRegions; i++) begin
      if (tbl_valid[i] && tbl_start[i] <= a &&
          (best < 0 || tbl_start[i] > tbl_start[best])) best = i;
    end
    return best;
  endfunction

  // valid region with the smallest start above a
  function automatic int region_above(logic [31:0] a);
    int best;
    best = -1;
    for (int i = 0; i < MaxRegions; i++) begin
      if (tbl_valid[i] && tbl_start[i] > a &&
          (best < 0 || tbl_start[i] < tbl_start[best])) best = i;
    end
    return best;
  endfunction

  function automatic resp_t region_view(int s);
    resp_t       r;
    logic [32:0] e;
    e         = end_of(s);
    r.status  = ST_OK;
    r.slot    = s[3:0];
    r.rstart  = tbl_start[s];
    r.rlength = tbl_length[s];
    r.rflags  = tbl_flags[s];
    r.fstart  = e[31:0];
    r.fend    = r.fstart;
    return r;
  endfunction

  function automatic resp_t fault(status_e st);
    resp_t r;
    r = '{status: st, slot: '0, rstart: '0, rlength: '0, rflags: '0,
          fstart: '0, fend: '0};
    return r;
  endfunction

  // apply one request to the table copy and return the response
  function automatic resp_t apply_request(func_e fn, logic [31:0] addr,
                                          logic [31:0] len, logic [7:0] flg,
                                          logic [3:0] sl);
    logic [32:0] new_end;
    logic [32:0] old_end;
    resp_t       r;
    int          p;
    int          n;
    int          s;
    s = -1;
    case (fn)
      FUNC_FIND: begin
        if (kernel_q) return fault(ST_KERNEL);
        for (int i = 0; i < MaxRegions; i++) begin
          if (s < 0 && tbl_valid[i] && tbl_start[i] <= addr && {1'b0, addr} < end_of(i))
            s = i;
        end
        if (s < 0) return fault(ST_NOT_FOUND);
        return region_view(s);
      end
      FUNC_CREATE: begin
        new_end = {1'b0, addr} + {1'b0, len};
        if (kernel_q) return fault(ST_KERNEL);
        if (addr[11:0] != 0 || len[11:0] != 0) return fault(ST_MISALIGN);
        if (new_end[32]) return fault(ST_WRAPS);
        if (addr == 0 || new_end >= {1'b0, UserLimit}) return fault(ST_RANGE);
        p = region_below(addr);
        n = region_above(addr);
        if ((p >= 0 && {1'b0, addr} <= end_of(p)) ||
            (n >= 0 && {1'b0, tbl_start[n]} <= new_end)) return fault(ST_OVERLAP);
        for (int i = 0; i < MaxRegions; i++) begin
          if (s < 0 && !tbl_valid[i]) s = i;
        end
        if (s < 0) return fault(ST_FULL);
        tbl_valid[s]  = 1'b1;
        tbl_start[s]  = addr;
        tbl_length[s] = len;
        tbl_flags[s]  = flg & mask_q;
        return region_view(s);
      end
      default: begin
        if (!tbl_valid[sl]) return fault(ST_BAD_SLOT);
        s = sl;
        if (fn == FUNC_DELETE) begin
          r = region_view(s);
          r.fstart  = tbl_start[s];
          r.rlength = '0;
          tbl_valid[s] = 1'b0;
          return r;
        end
        new_end = {1'b0, tbl_start[s]} + {1'b0, len};
        if (len[11:0] != 0) return fault(ST_MISALIGN);
        if (len < tbl_length[s]) begin
          // shrink: report the released tail
          old_end = end_of(s);
          tbl_length[s] = len;
          r = region_view(s);
          r.fstart = new_end[31:0];
          r.fend   = old_end[31:0];
          return r;
        end
        if (new_end[32]) return fault(ST_WRAPS);
        if (new_end > {1'b0, UserLimit}) return fault(ST_RANGE);
        n = region_above(tbl_start[s]);
        if (n >= 0 && {1'b0, tbl_start[n]} <= new_end) return fault(ST_OVERLAP);
        tbl_length[s] = len;
        return region_view(s);
      end
    endcase
  endfunction

  //----------------------------------------------------------------------------
  // Request side
  //----------------------------------------------------------------------------
  task automatic send_request(func_e fn, logic [31:0] addr, logic [31:0] len,
                              logic [7:0] flg, logic [3:0] sl);
    // idle at random before offering
    while (!steady && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, sl, flg, len, addr, fn};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_resp.push_back(apply_request(fn, addr, len, flg, sl));
    requests_sent++;
  endtask

  // drop valid and wait until every response has arrived and the block settled
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [7:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgKernel) kernel_q = value[0];
    else mask_q = value;
    cfg_settings++;
  endtask

  //----------------------------------------------------------------------------
  // Response side
  //----------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else begin
      m_axis_tready <= steady || $urandom_range(99) >= 24;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH response %0d %s: got 0x%0h expected 0x%0h",
             responses_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    resp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_resp.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata[31:0], '0);
      end else begin
        want = pending_resp.pop_front();
        if (want.status < 9) status_hits[want.status]++;
        if (m_axis_tdata[3:0] !== want.status)
          report_mismatch("status", 32'(m_axis_tdata[3:0]), 32'(want.status));
        if (m_axis_tdata[7:4] !== want.slot)
          report_mismatch("found_slot", 32'(m_axis_tdata[7:4]), 32'(want.slot));
        if (m_axis_tdata[39:8] !== want.rstart)
          report_mismatch("region_start", m_axis_tdata[39:8], want.rstart);
        if (m_axis_tdata[71:40] !== want.rlength)
          report_mismatch("region_length", m_axis_tdata[71:40], want.rlength);
        if (m_axis_tdata[79:72] !== want.rflags)
          report_mismatch("region_flags", 32'(m_axis_tdata[79:72]), 32'(want.rflags));
        if (m_axis_tdata[111:80] !== want.fstart)
          report_mismatch("freed_start", m_axis_tdata[111:80], want.fstart);
        if (m_axis_tdata[143:112] !== want.fend)
          report_mismatch("freed_end", m_axis_tdata[143:112], want.fend);
      end
      responses_seen++;
    end
  end

  //----------------------------------------------------------------------------
  // Tests
  //----------------------------------------------------------------------------
  function automatic int any_valid_slot();
    int pick;
    int cnt;
    pick = -1;
    cnt  = 0;
    for (int i = 0; i < MaxRegions; i++) begin
      if (tbl_valid[i]) begin
        cnt++;
        if ($urandom_range(cnt - 1) == 0) pick = i;
      end
    end
    return pick;
  endfunction

  task automatic clear_table;
    for (int i = 0; i < MaxRegions; i++) begin
      if (tbl_valid[i]) send_request(FUNC_DELETE, '0, '0, '0, i[3:0]);
    end
  endtask

  // directed checks of create and find edges
  task automatic test_create_find;
    send_request(FUNC_CREATE, 32'h0000_1000, 32'h0000_1000, 8'hFF, 4'd0);
    send_request(FUNC_FIND,   32'h0000_1FFF, 32'hFFFF_FFFF, 8'h00, 4'hF);
    send_request(FUNC_FIND,   32'h0000_2000, '0, '0, '0);       // just past end
    send_request(FUNC_CREATE, 32'h0000_2000, 32'h0000_1000, 8'h5A, 4'd0); // touches prev end
    send_request(FUNC_CREATE, 32'h0000_3000, 32'h0000_2000, 8'hA5, 4'd0);
    send_request(FUNC_CREATE, 32'h0000_8000, 32'h0001_0000, 8'h01, 4'd0);
    send_request(FUNC_CREATE, 32'h0000_6000, 32'h0000_2000, 8'h02, 4'd0); // reaches next start
    send_request(FUNC_CREATE, 32'h0000_2800, 32'h0000_1000, 8'h00, 4'd0); // misaligned start
    send_request(FUNC_CREATE, 32'h0010_0000, 32'h0000_0800, 8'h00, 4'd0); // misaligned length
    send_request(FUNC_CREATE, 32'hFFFF_F000, 32'h0000_2000, 8'h00, 4'd0); // wraps
    send_request(FUNC_CREATE, 32'h0000_0000, 32'h0000_1000, 8'h00, 4'd0); // zero start
    send_request(FUNC_CREATE, 32'hBFFF_F000, 32'h0000_1000, 8'h00, 4'd0); // ends at limit
    send_request(FUNC_CREATE, 32'hBFFF_E000, 32'h0000_1000, 8'hFF, 4'd0);
    send_request(FUNC_CREATE, 32'h0040_0000, 32'h0000_0000, 8'h80, 4'd0); // zero length
    send_request(FUNC_FIND,   32'h0040_0000, '0, '0, '0);
  endtask

  // directed checks of resize and delete edges
  task automatic test_resize_delete;
    send_request(FUNC_RESIZE, '0, 32'h0000_1000, '0, 4'd1);      // shrink
    send_request(FUNC_RESIZE, '0, 32'h0000_1000, '0, 4'd2);      // shrink
    send_request(FUNC_RESIZE, '0, 32'h0000_5000, '0, 4'd2);      // grow
    send_request(FUNC_RESIZE, '0, 32'h0000_1800, '0, 4'd2);      // misaligned
    send_request(FUNC_RESIZE, '0, 32'h0000_2000, '0, 4'd3);      // grow to exactly limit
    send_request(FUNC_RESIZE, '0, 32'h0000_3000, '0, 4'd3);      // beyond limit
    send_request(FUNC_RESIZE, '0, 32'hFFFF_F000, '0, 4'd3);      // wraps
    send_request(FUNC_RESIZE, '0, 32'h0000_0000, '0, 4'd3);      // shrink to zero
    send_request(FUNC_RESIZE, '0, 32'h0000_1000, '0, 4'hF);      // unused slot
    send_request(FUNC_DELETE, '0, '0, '0, 4'd0);
    send_request(FUNC_DELETE, '0, '0, '0, 4'd0);                 // already free
    send_request(FUNC_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF);
    drain();
  endtask

  // fill every slot, then one more create
  task automatic test_full_table;
    clear_table();
    for (int i = 0; i <= MaxRegions; i++)
      send_request(FUNC_CREATE, (i + 1) << 16, 32'h0000_2000, i[7:0], '0);
    send_request(FUNC_FIND, 32'h0011_1FFF, '0, '0, '0);
    clear_table();
    drain();
  endtask

  // kernel context refuses find and create only
  task automatic test_kernel_context;
    send_request(FUNC_CREATE, 32'h0000_1000, 32'h0000_1000, 8'h3C, '0);
    write_reg(CfgKernel, 8'h01);
    send_request(FUNC_FIND,   32'h0000_1000, '0, '0, '0);
    send_request(FUNC_CREATE, 32'h0002_0000, 32'h0000_1000, 8'h00, '0);
    send_request(FUNC_RESIZE, '0, 32'h0000_3000, '0, 4'd0);
    send_request(FUNC_DELETE, '0, '0, '0, 4'd0);
    write_reg(CfgKernel, 8'h00);
  endtask

  // mostly well-formed traffic on live slots, with some noise
  task automatic test_random_traffic(int count);
    int          s;
    int          pick;
    logic [31:0] addr;
    logic [31:0] len;
    for (int k = 0; k < count; k++) begin
      steady = (k % 300) >= 220 && (k % 300) < 280;
      pick   = $urandom_range(99);
      s      = any_valid_slot();
      len    = $urandom_range(0, 8) << 12;
      if (pick < 12) begin
        send_request(func_e'($urandom_range(3)), $urandom, $urandom, 8'($urandom),
                     4'($urandom_range(15)));
      end else if (pick < 42 || s < 0) begin
        addr = ($urandom_range(9) == 0) ? ($urandom_range(1, 20'hBFFFF) << 12)
                                        : ($urandom_range(1, 96) << 12);
        send_request(FUNC_CREATE, addr, len, 8'($urandom), 4'($urandom_range(15)));
      end else if (pick < 64) begin
        addr = tbl_start[s] + $urandom_range(0, tbl_length[s]);
        send_request(FUNC_FIND, addr, $urandom, 8'($urandom), 4'($urandom_range(15)));
      end else if (pick < 84) begin
        if ($urandom_range(19) == 0) len = $urandom_range(1, 20'hFFFFF) << 12;
        send_request(FUNC_RESIZE, $urandom, len, 8'($urandom), s[3:0]);
      end else begin
        send_request(FUNC_DELETE, $urandom, $urandom, 8'($urandom), s[3:0]);
      end
    end
    steady = 1'b0;
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure;
    drain();
    hold_cycles = 300;
    for (int k = 0; k < 20; k++)
      send_request(FUNC_FIND, $urandom_range(1, 96) << 12, '0, '0, '0);
    drain();
  endtask

  //----------------------------------------------------------------------------
  // Sequence
  //----------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgKernel;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    hold_cycles   = 0;
    steady        = 1'b0;
    kernel_q      = 1'b0;
    mask_q        = 8'hFF;
    for (int i = 0; i < MaxRegions; i++) begin
      tbl_valid[i]  = 1'b0;
      tbl_start[i]  = '0;
      tbl_length[i] = '0;
      tbl_flags[i]  = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_create_find();
    test_resize_delete();
    test_full_table();
    test_kernel_context();
    test_random_traffic(350);
    write_reg(CfgMask, 8'h00);
    test_random_traffic(250);
    write_reg(CfgMask, 8'($urandom_range(1, 254)));
    test_backpressure();
    test_random_traffic(250);
    write_reg(CfgKernel, 8'h01);
    test_random_traffic(60);
    write_reg(CfgKernel, 8'h00);
    write_reg(CfgMask, 8'hFF);
    test_random_traffic(260);
    drain();

    $display("Ran %0d requests over %0d register writes, %0d responses checked.",
             requests_sent, cfg_settings, responses_seen);
    $display("Status counts ok/nf/kern/align/wrap/range/ovl/full/slot: %0p", status_hits);
    if (mismatches == 0 && pending_resp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/art_pkg.sv
rtl/art_ram.sv
rtl/address_region_table.sv
tb/tb_address_region_table.sv
